[rtl/core/lba_pkg.sv]
// Package for the linked block allocator: sizes, operation and status codes.
// No dependencies.
package lba_pkg;
    localparam int BLOCKS_DEF = 64;
    localparam int SLOTS_DEF  = 16;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BUSY   = 3'd1;
    localparam logic [2:0] ST_UNUSED = 3'd2;
    localparam logic [2:0] ST_ZERO   = 3'd3;
    localparam logic [2:0] ST_NOROOM = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] slot;
        logic [6:0] count;
        logic [2:0] status;
    } t_cmd;
endpackage

[rtl/core/lba_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
interface lba_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [3:0] file_slot;
    logic [6:0] block_count;
    modport source (output valid, operation, file_slot, block_count, input ready);
    modport sink   (input valid, operation, file_slot, block_count, output ready);
endinterface

interface lba_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] block_number;
    logic       last;
    logic [2:0] status;
    logic [6:0] freed_count;
    modport source (output valid, block_number, last, status, freed_count, input ready);
    modport sink   (input valid, block_number, last, status, freed_count, output ready);
endinterface

[rtl/core/lba_ram.sv]
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module lba_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/lba_front.sv]
// Front end: accepts commands, checks slot state and free total, holds one.
// Depends on lba_pkg and lba_if.
module lba_front #(
    parameter int BLOCKS = lba_pkg::BLOCKS_DEF,
    parameter int SLOTS  = lba_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lba_cmd_if.sink       cmd,
    output logic          o_valid,
    output lba_pkg::t_cmd o_cmd,
    input  logic          i_take,
    input  logic          i_done
);
    import lba_pkg::*;
    localparam int CW = $clog2(BLOCKS + 1);
    localparam int SW = $clog2(SLOTS);

    logic [SLOTS-1:0] r_used;
    logic [6:0]       r_total [SLOTS];
    logic [CW-1:0]    r_free;
    logic             r_full, r_busy;
    t_cmd             r_q;
    t_cmd             n_q;
    logic             ok_slot, in_use, acc;
    logic [SW-1:0]    slot_idx;

    assign slot_idx  = SW'(cmd.file_slot);
    assign ok_slot   = 32'(cmd.file_slot) < SLOTS;
    assign in_use    = ok_slot && r_used[slot_idx];
    assign cmd.ready = !r_full && !r_busy;
    assign acc       = cmd.valid && cmd.ready;
    assign o_valid   = r_full;
    assign o_cmd     = r_q;

    always_comb begin
        n_q        = '0;
        n_q.op     = cmd.operation;
        n_q.slot   = 6'(cmd.file_slot);
        n_q.count  = cmd.block_count;
        n_q.status = ST_OK;
        if (cmd.operation == OP_ALLOC) begin
            if (in_use) n_q.status = ST_BUSY;
            else if (cmd.block_count == 7'd0) n_q.status = ST_ZERO;
            else if (32'(cmd.block_count) > 32'(r_free)) n_q.status = ST_NOROOM;
        end else begin
            if (!in_use) n_q.status = ST_UNUSED;
            else n_q.count = r_total[slot_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_free <= CW'(BLOCKS - 5);
            r_full <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (i_take) begin
                r_full <= 1'b0;
                r_busy <= 1'b1;
            end
            if (i_done) r_busy <= 1'b0;
            if (acc && ok_slot && cmd.operation != 2'd3) begin
                r_full <= 1'b1;
                r_q    <= n_q;
                if (n_q.status == ST_OK && cmd.operation == OP_ALLOC) begin
                    r_used[slot_idx]  <= 1'b1;
                    r_total[slot_idx] <= cmd.block_count;
                    r_free <= r_free - CW'(cmd.block_count);
                end
                if (n_q.status == ST_OK && cmd.operation == OP_DELETE) begin
                    r_used[slot_idx] <= 1'b0;
                    r_free <= r_free + CW'(n_q.count);
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_take |-> r_full);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= BLOCKS);
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_full |-> !cmd.ready);
endmodule

[rtl/core/lba_back.sv]
// Back end: walks the free map and the chain table, emits results.
// Depends on lba_pkg, lba_if and lba_ram.
module lba_back #(
    parameter int BLOCKS = lba_pkg::BLOCKS_DEF,
    parameter int SLOTS  = lba_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lba_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_done,
    lba_res_if.source     res
);
    import lba_pkg::*;
    localparam int BW = $clog2(BLOCKS);
    localparam int SW = $clog2(SLOTS);

    typedef enum logic [2:0] {S_IDLE, S_ALLOC, S_RD, S_WALK, S_OUT} t_state;
    t_state r_state;

    logic [BLOCKS-1:0] r_free;
    logic [BW-1:0]     r_first [SLOTS];
    t_cmd              r_c;
    logic [BW-1:0]     r_b, r_cur;
    logic [6:0]        r_n;
    logic              r_ov;
    logic [5:0]        r_ob;
    logic              r_ol;
    logic [2:0]        r_os;
    logic [6:0]        r_of;
    logic              we;
    logic [BW-1:0]     rd_addr, rdata;
    logic              room;

    assign room     = !r_ov || res.ready;
    assign o_take   = i_valid && r_state == S_IDLE && room;
    assign res.valid = r_ov;
    assign res.block_number = r_ob;
    assign res.last = r_ol;
    assign res.status = r_os;
    assign res.freed_count = r_of;
    assign we = r_state == S_ALLOC && room && r_free[r_b] && r_n != 7'd0;
    assign rd_addr = (r_state == S_WALK) ? rdata : r_cur;

    lba_ram #(.WIDTH(BW), .DEPTH(BLOCKS)) u_next (
        .i_clk, .i_we(we), .i_waddr(r_cur), .i_wdata(r_b),
        .i_raddr(rd_addr), .o_rdata(rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            o_done  <= 1'b0;
            r_free  <= {BLOCKS{1'b1}} & ~(BLOCKS'(1) | BLOCKS'(8) | BLOCKS'(32)
                       | BLOCKS'(512) | BLOCKS'(1024));
        end else begin
            o_done <= 1'b0;
            if (r_ov && res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_take) begin
                    r_c <= i_cmd;
                    r_n <= 7'd0;
                    r_b <= '0;
                    r_cur <= r_first[i_cmd.slot[SW-1:0]];
                    if (i_cmd.status != ST_OK) begin
                        r_ov <= 1'b1; r_ob <= '0; r_ol <= 1'b1;
                        r_os <= i_cmd.status; r_of <= '0; o_done <= 1'b1;
                    end else if (i_cmd.op == OP_ALLOC) r_state <= S_ALLOC;
                    else if (i_cmd.count == 7'd0) begin
                        r_ov <= 1'b1; r_ob <= '0; r_ol <= 1'b1;
                        r_os <= ST_OK; r_of <= '0; o_done <= 1'b1;
                    end else r_state <= S_OUT;
                end
                S_ALLOC: if (room) begin
                    if (r_free[r_b]) begin
                        r_free[r_b] <= 1'b0;
                        if (r_n == 7'd0) r_first[r_c.slot[SW-1:0]] <= r_b;
                        r_cur <= r_b;
                        r_n   <= r_n + 7'd1;
                        r_ov <= 1'b1; r_ob <= 6'(r_b); r_os <= ST_OK; r_of <= '0;
                        r_ol <= r_n + 7'd1 == r_c.count;
                        if (r_n + 7'd1 == r_c.count) begin
                            r_state <= S_IDLE; o_done <= 1'b1;
                        end
                    end
                    r_b <= r_b + BW'(1);
                end
                S_OUT: if (room) begin
                    if (r_c.op == OP_DELETE) r_free[r_cur] <= 1'b1;
                    else begin
                        r_ov <= 1'b1; r_ob <= 6'(r_cur); r_os <= ST_OK; r_of <= '0;
                        r_ol <= r_n + 7'd1 == r_c.count;
                    end
                    r_n <= r_n + 7'd1;
                    if (r_n + 7'd1 == r_c.count) begin
                        r_state <= S_IDLE; o_done <= 1'b1;
                        if (r_c.op == OP_DELETE) begin
                            r_ov <= 1'b1; r_ob <= '0; r_ol <= 1'b1;
                            r_os <= ST_OK; r_of <= r_c.count;
                        end
                    end else r_state <= S_RD;
                end
                S_RD: r_state <= S_WALK;
                S_WALK: begin
                    r_cur <= rdata;
                    r_state <= S_OUT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_state == S_ALLOC);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_ov && r_ol);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == S_IDLE);
endmodule

[rtl/core/linked_block_allocator.sv]
// Linked block allocator: a front end that checks commands and queues one,
// and a back end that walks the bitmap and the chain table. Allocate scans
// one block a cycle while the result output is empty or being taken.
// List and delete visit each chain link through the states S_OUT, S_RD and
// S_WALK, reading the registered next-block RAM. An error gives a single
// result, with last set.
module linked_block_allocator #(
    parameter int BLOCKS = lba_pkg::BLOCKS_DEF,
    parameter int SLOTS  = lba_pkg::SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lba_cmd_if.sink   cmd,
    lba_res_if.source res
);
    import lba_pkg::*;
    logic v, take, done;
    t_cmd c;

    lba_front #(.BLOCKS(BLOCKS), .SLOTS(SLOTS)) u_front (
        .i_clk, .i_rst_n, .cmd, .o_valid(v), .o_cmd(c), .i_take(take), .i_done(done));
    lba_back #(.BLOCKS(BLOCKS), .SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(v), .i_cmd(c), .o_take(take), .o_done(done), .res);
endmodule
